/* design/assert_macros.svh */
// assertion helpers used by the table design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/slkt_pkg.sv */
`timescale 1ns / 1ps

package slkt_pkg;

   localparam int CAPACITY = 16;
   localparam int MAX_RES  = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 4;
   localparam int LIST_MAX = (CAPACITY < MAX_RES) ? CAPACITY : MAX_RES;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_LIST   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_EMPTY   = 2'd2,
      STAT_MISSING = 2'd3
   } stat_type;

   typedef struct packed {
      logic [39:0] w3;
      logic [63:0] w2;
      logic [63:0] w1;
      logic [63:0] w0;
   } key_type;

   typedef struct packed {
      logic [23:0] w2;
      logic [63:0] w1;
      logic [63:0] w0;
   } kind_type;

   typedef struct packed {
      key_type            key;
      kind_type           kind;
      logic signed [31:0] amount;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // compare unit flags for the sequencer
   typedef struct packed {
      logic hit;       // stored key equals request key
      logic at_end;    // current index is the last filled entry
      logic more_two;  // index + 2 still below the count
   } scan_flags_type;

   function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
      logic [IDX_W+POS_W-1:0] wide;
      wide = {{POS_W{1'b0}}, idx};
      return wide[POS_W-1:0];
   endfunction

endpackage

/* design/slkt_req_if.sv */
`timescale 1ns / 1ps

interface slkt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [63:0]        key_word0;
   logic [63:0]        key_word1;
   logic [63:0]        key_word2;
   logic [39:0]        key_word3;
   logic [63:0]        kind_word0;
   logic [63:0]        kind_word1;
   logic [23:0]        kind_word2;
   logic signed [31:0] amount;

   modport source (
      output valid, func, key_word0, key_word1, key_word2, key_word3,
             kind_word0, kind_word1, kind_word2, amount,
      input  ready
   );

   modport sink (
      input  valid, func, key_word0, key_word1, key_word2, key_word3,
             kind_word0, kind_word1, kind_word2, amount,
      output ready
   );
endinterface

/* design/slkt_rsp_if.sv */
`timescale 1ns / 1ps

interface slkt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [3:0]         position;
   logic [63:0]        out_key_word0;
   logic [63:0]        out_key_word1;
   logic [63:0]        out_key_word2;
   logic [39:0]        out_key_word3;
   logic [63:0]        out_kind_word0;
   logic [63:0]        out_kind_word1;
   logic [23:0]        out_kind_word2;
   logic signed [31:0] out_amount;
   logic               last;

   modport source (
      output valid, status, position, out_key_word0, out_key_word1, out_key_word2,
             out_key_word3, out_kind_word0, out_kind_word1, out_kind_word2,
             out_amount, last,
      input  ready
   );

   modport sink (
      input  valid, status, position, out_key_word0, out_key_word1, out_key_word2,
             out_key_word3, out_kind_word0, out_kind_word1, out_kind_word2,
             out_amount, last,
      output ready
   );
endinterface

/* design/slkt_ram.sv */
`timescale 1ns / 1ps

module slkt_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/slkt_cmp.sv */
`timescale 1ns / 1ps

module slkt_cmp (
   input  slkt_pkg::key_type         stored_key,
   input  slkt_pkg::key_type         probe_key,
   input  logic [slkt_pkg::IDX_W-1:0] idx,
   input  logic [slkt_pkg::CNT_W-1:0] count,
   output slkt_pkg::scan_flags_type  flags
);
   import slkt_pkg::*;

   logic [CNT_W:0] idx_ext;
   logic [CNT_W:0] cnt_ext;

   always_comb begin
      idx_ext        = {{(CNT_W + 1 - IDX_W){1'b0}}, idx};
      cnt_ext        = {1'b0, count};
      flags.hit      = (stored_key == probe_key);
      flags.at_end   = ((idx_ext + 1'b1) == cnt_ext);
      flags.more_two = ((idx_ext + 2'd2) < cnt_ext);
   end

endmodule

/* design/sequential_list_keyed_table.sv */
// insert, full and empty answers pass dispatch and the response state into the output register
// search and remove compare one stored entry per scan and check through a single compare unit
// remove then copies each later entry down with one ram read and one ram write
// list emits its results one at a time; a new request is taken only once the sequencer is idle
// reset clears the sequencer, the entry count and the output valid; the record ram is not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sequential_list_keyed_table (
   input  logic       clock,
   input  logic       reset,
   slkt_req_if.sink   req_if,
   slkt_rsp_if.source rsp_if
);
   import slkt_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DISPATCH = 9'b000000010,
      ST_SCAN     = 9'b000000100,
      ST_CHECK    = 9'b000001000,
      ST_SHIFT_RD = 9'b000010000,
      ST_SHIFT_WR = 9'b000100000,
      ST_LIST_RD  = 9'b001000000,
      ST_LIST_LD  = 9'b010000000,
      ST_RESP     = 9'b100000000
   } state_type;

   // sequencer state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   stat_type          stat_ff, stat_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              rec_ff, rec_in;      // pending answer carries the ram record

   // latched request
   func_type          func_ff;
   rec_type           req_rec_ff;

   // output register
   logic              rsp_valid_ff;
   stat_type          rsp_stat_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   rec_type           rsp_rec_ff;
   logic              rsp_last_ff;

   // push into the output register
   logic              push;
   stat_type          push_stat;
   logic [POS_W-1:0]  push_pos;
   logic              push_rec;
   logic              push_last;

   // ram control
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   rec_type           wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   rec_type           rd_data;

   logic              req_xfer;
   logic              out_free;
   logic [CNT_W-1:0]  list_n;
   logic [CNT_W-1:0]  idx_cnt;
   scan_flags_type    flags;

   assign req_xfer  = req_if.valid && req_if.ready;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   // listing stops at the result limit
   assign list_n  = (count_ff > CNT_W'(LIST_MAX)) ? CNT_W'(LIST_MAX) : count_ff;
   assign idx_cnt = {{(CNT_W - IDX_W){1'b0}}, idx_ff} + 1'b1;

   slkt_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (REC_W),
      .ADDR_W(IDX_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // the one key compare shared by search and remove
   slkt_cmp u_cmp (
      .stored_key(rd_data.key),
      .probe_key (req_rec_ff.key),
      .idx       (idx_ff),
      .count     (count_ff),
      .flags     (flags)
   );

   // request latch
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff              <= func_type'(req_if.func);
         req_rec_ff.key.w0    <= req_if.key_word0;
         req_rec_ff.key.w1    <= req_if.key_word1;
         req_rec_ff.key.w2    <= req_if.key_word2;
         req_rec_ff.key.w3    <= req_if.key_word3;
         req_rec_ff.kind.w0   <= req_if.kind_word0;
         req_rec_ff.kind.w1   <= req_if.kind_word1;
         req_rec_ff.kind.w2   <= req_if.kind_word2;
         req_rec_ff.amount    <= req_if.amount;
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      stat_in   = stat_ff;
      pos_in    = pos_ff;
      rec_in    = rec_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      push      = 1'b0;
      push_stat = stat_ff;
      push_pos  = pos_ff;
      push_rec  = rec_ff;
      push_last = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               idx_in   = '0;
               rec_in   = 1'b0;
               stat_in  = STAT_OK;
               pos_in   = '0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (func_ff == FUNC_INSERT) begin
               if (count_ff >= CNT_W'(CAPACITY)) begin
                  stat_in = STAT_FULL;
               end else begin
                  // append at the current fill level
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = req_rec_ff;
                  pos_in   = to_pos(count_ff[IDX_W-1:0]);
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_RESP;
            end else if (count_ff == '0) begin
               stat_in  = STAT_EMPTY;
               state_in = ST_RESP;
            end else if (func_ff == FUNC_LIST) begin
               state_in = ST_LIST_RD;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (flags.hit) begin
               pos_in = to_pos(idx_ff);
               if (func_ff == FUNC_SEARCH) begin
                  rec_in   = 1'b1;
                  state_in = ST_RESP;
               end else if (!flags.at_end) begin
                  state_in = ST_SHIFT_RD;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_RESP;
               end
            end else if (flags.at_end) begin
               stat_in  = STAT_MISSING;
               state_in = ST_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SHIFT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff + 1'b1;
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            if (flags.more_two) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SHIFT_RD;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_LIST_RD: begin
            rd_en    = 1'b1;
            state_in = ST_LIST_LD;
         end
         ST_LIST_LD: begin
            if (out_free) begin
               push      = 1'b1;
               push_stat = STAT_OK;
               push_pos  = to_pos(idx_ff);
               push_rec  = 1'b1;
               push_last = (idx_cnt == list_n);
               if (idx_cnt == list_n) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_LIST_RD;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      stat_ff <= stat_in;
      pos_ff  <= pos_in;
      rec_ff  <= rec_in;
   end

   // output register, freed by a transfer on the result side
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_stat_ff <= push_stat;
         rsp_pos_ff  <= push_pos;
         rsp_rec_ff  <= push_rec ? rd_data : '0;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_stat_ff;
   assign rsp_if.position       = rsp_pos_ff;
   assign rsp_if.out_key_word0  = rsp_rec_ff.key.w0;
   assign rsp_if.out_key_word1  = rsp_rec_ff.key.w1;
   assign rsp_if.out_key_word2  = rsp_rec_ff.key.w2;
   assign rsp_if.out_key_word3  = rsp_rec_ff.key.w3;
   assign rsp_if.out_kind_word0 = rsp_rec_ff.kind.w0;
   assign rsp_if.out_kind_word1 = rsp_rec_ff.kind.w1;
   assign rsp_if.out_kind_word2 = rsp_rec_ff.kind.w2;
   assign rsp_if.out_amount     = rsp_rec_ff.amount;
   assign rsp_if.last           = rsp_last_ff;

   // fill level never passes the capacity
   `ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   // the scan only visits filled entries
   `ASSERT_IMP(a_scan_bound, clock, reset,
               (state_ff == ST_SCAN) || (state_ff == ST_CHECK),
               idx_cnt <= count_ff)
   // an error answer is a single result at position zero
   `ASSERT_IMP(a_err_single, clock, reset,
               rsp_valid_ff && (rsp_stat_ff != STAT_OK),
               rsp_last_ff && (rsp_pos_ff == '0))
   // a full answer only comes from a full list
   `ASSERT_IMP(a_full_count, clock, reset,
               push && (push_stat == STAT_FULL),
               count_ff == CNT_W'(CAPACITY))
   // a result still waiting stays valid until it is taken
   `ASSERT_NXT(a_no_overrun, clock, reset,
               rsp_valid_ff && !rsp_if.ready && !push,
               rsp_valid_ff)

endmodule

/* tb/tb_sequential_list_keyed_table.sv */
`timescale 1ns / 1ps

module tb_sequential_list_keyed_table;
   import slkt_pkg::*;

   // run length guard: a few hundred items, each at most 16 results, each result
   // passing through the block plus a short receiver stall, taken many times over
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int HOLD_CYCLES    = 150;   // long receiver hold-off for the pressure test
   localparam int SETTLE_CYCLES  = 40;    // quiet cycles after the last result
   localparam int NAME_POOL      = 10;    // small name pool so lookups hit and names repeat
   localparam int RANDOM_ITEMS   = 395;

   typedef struct {
      stat_type           status;
      logic [3:0]         position;
      key_type            key;
      kind_type           kind;
      logic signed [31:0] amount;
      logic               last;
   } table_answer_type;

   // receiver stall patterns
   typedef enum int {
      RX_STEADY,
      RX_COIN,
      RX_EVERY_FOURTH,
      RX_MOSTLY
   } rx_mode_type;

   logic clock;
   logic reset;

   slkt_req_if req_if ();
   slkt_rsp_if rsp_if ();

   sequential_list_keyed_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // --------------------------------------------------------------------------
   // shadow copy of the table, kept in step with every accepted request
   // --------------------------------------------------------------------------
   rec_type          table_rec [CAPACITY];
   int               fill_count;
   table_answer_type pending_answers [$];

   // run statistics for the closing summary
   int func_seen [4];
   int status_seen [4];
   int longest_list;
   int results_checked;
   int input_stall_cycles;
   int error_count;
   int cycle_count;

   // pressure control between the test tasks and the receiver
   bit          hold_request;
   int          hold_left;
   rx_mode_type stall_mode;
   int          mode_left;
   int          rx_phase;

   // names reused across the random part, plus names picked by the directed part
   key_type name_pool [NAME_POOL];
   key_type dup_name;
   key_type tail_name;

   // one answer onto the queue; rec_idx below zero leaves the record fields at zero
   function automatic void push_answer(stat_type st, int pos, int rec_idx, bit is_last);
      table_answer_type ans;
      ans.status   = st;
      ans.position = 4'(pos);
      ans.key      = '0;
      ans.kind     = '0;
      ans.amount   = '0;
      ans.last     = is_last;
      if (rec_idx >= 0) begin
         ans.key    = table_rec[rec_idx].key;
         ans.kind   = table_rec[rec_idx].kind;
         ans.amount = table_rec[rec_idx].amount;
      end
      status_seen[int'(st)]++;
      pending_answers.push_back(ans);
   endfunction

   // works out every answer that one accepted request causes and updates the shadow table
   function automatic void predict_table_answer(func_type f, key_type k, kind_type kd,
                                                logic signed [31:0] amt);
      int hit;
      int n;
      hit = -1;
      func_seen[int'(f)]++;
      if (f == FUNC_INSERT) begin
         if (fill_count >= CAPACITY) begin
            push_answer(STAT_FULL, 0, -1, 1'b1);
         end else begin
            table_rec[fill_count].key    = k;
            table_rec[fill_count].kind   = kd;
            table_rec[fill_count].amount = amt;
            push_answer(STAT_OK, fill_count, -1, 1'b1);
            fill_count++;
         end
      end else if (fill_count == 0) begin
         push_answer(STAT_EMPTY, 0, -1, 1'b1);
      end else if (f == FUNC_LIST) begin
         n = (fill_count < LIST_MAX) ? fill_count : LIST_MAX;
         for (int i = 0; i < n; i++) begin
            push_answer(STAT_OK, i, i, i == n - 1);
         end
         if (n > longest_list) begin
            longest_list = n;
         end
      end else begin
         // first match wins, so duplicates resolve to the lowest index
         for (int i = 0; i < fill_count; i++) begin
            if (hit < 0 && table_rec[i].key == k) begin
               hit = i;
            end
         end
         if (hit < 0) begin
            push_answer(STAT_MISSING, 0, -1, 1'b1);
         end else if (f == FUNC_SEARCH) begin
            push_answer(STAT_OK, hit, hit, 1'b1);
         end else begin
            // remove closes the gap by moving later entries down one slot
            for (int i = hit; i < fill_count - 1; i++) begin
               table_rec[i] = table_rec[i + 1];
            end
            fill_count--;
            push_answer(STAT_OK, hit, -1, 1'b1);
         end
      end
   endfunction

   // --------------------------------------------------------------------------
   // random field helpers
   // --------------------------------------------------------------------------

   // random name; half the time cut to a random length and zero padded like a real string
   function automatic key_type random_key();
      logic [$bits(key_type)-1:0] bits;
      int                         len;
      bits = {8'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom};
      if ($urandom_range(0, 1) == 1) begin
         len  = $urandom_range(0, 29);
         bits = bits & ~({$bits(key_type){1'b1}} << (8 * len));
      end
      return key_type'(bits);
   endfunction

   function automatic kind_type random_kind();
      logic [$bits(kind_type)-1:0] bits;
      int                          len;
      bits = {24'($urandom), $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 1) == 1) begin
         len  = $urandom_range(0, 19);
         bits = bits & ~({$bits(kind_type){1'b1}} << (8 * len));
      end
      return kind_type'(bits);
   endfunction

   // same as a known name except for one bit, so the compare must look at every word
   function automatic key_type near_miss(key_type k);
      logic [$bits(key_type)-1:0] bits;
      int                         flip;
      bits       = k;
      flip       = $urandom_range(0, $bits(key_type) - 1);
      bits[flip] = ~bits[flip];
      return key_type'(bits);
   endfunction

   // name for a remove or search: mostly names that are likely stored
   function automatic key_type pick_lookup_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return name_pool[$urandom_range(0, NAME_POOL - 1)];
      end else if (r < 80 && fill_count > 0) begin
         return table_rec[$urandom_range(0, fill_count - 1)].key;
      end else if (r < 92) begin
         return near_miss(name_pool[$urandom_range(0, NAME_POOL - 1)]);
      end
      return random_key();
   endfunction

   // --------------------------------------------------------------------------
   // clock, reset and the timeout guard
   // --------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pending_answers.size());
      $display("FAIL");
      $finish;
   end

   // --------------------------------------------------------------------------
   // sender side: one request per call, driven at the falling edge
   // --------------------------------------------------------------------------

   // leaves valid high after the transfer so a following call keeps the burst going
   task automatic send_request(func_type f, key_type k, kind_type kd, logic signed [31:0] amt);
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.func       <= f;
      req_if.key_word0  <= k.w0;
      req_if.key_word1  <= k.w1;
      req_if.key_word2  <= k.w2;
      req_if.key_word3  <= k.w3;
      req_if.kind_word0 <= kd.w0;
      req_if.kind_word1 <= kd.w1;
      req_if.kind_word2 <= kd.w2;
      req_if.amount     <= amt;
      do begin
         @(posedge clock);
      end while (req_if.ready !== 1'b1);
      // the transfer happened at this edge
      predict_table_answer(f, k, kd, amt);
   endtask

   task automatic pause_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
   endtask

   // sender stops until every outstanding answer has been taken
   task automatic wait_for_drain();
      pause_sender(1);
      while (pending_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // receiver side: stall patterns, with a long hold-off on request
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 160);
         end
         mode_left--;
         rx_phase++;
         case (stall_mode)
            RX_STEADY: begin
               rsp_if.ready <= 1'b1;
            end
            RX_COIN: begin
               rsp_if.ready <= ($urandom_range(0, 1) == 1);
            end
            RX_EVERY_FOURTH: begin
               rsp_if.ready <= (rx_phase % 4 == 0);
            end
            default: begin
               rsp_if.ready <= ($urandom_range(0, 9) != 0);
            end
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // answer checker: each result transfer against the oldest expectation
   // --------------------------------------------------------------------------
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      table_answer_type want;
      if (!reset) begin
         if (req_if.valid === 1'b1 && req_if.ready !== 1'b1) begin
            input_stall_cycles++;
         end
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_answers.size() == 0) begin
               $error("result with nothing expected: status %0d position %0d",
                      rsp_if.status, rsp_if.position);
               error_count++;
            end else begin
               want = pending_answers.pop_front();
               results_checked++;
               check_field("status", 64'(want.status), 64'(rsp_if.status));
               check_field("position", 64'(want.position), 64'(rsp_if.position));
               check_field("out_key_word0", want.key.w0, rsp_if.out_key_word0);
               check_field("out_key_word1", want.key.w1, rsp_if.out_key_word1);
               check_field("out_key_word2", want.key.w2, rsp_if.out_key_word2);
               check_field("out_key_word3", 64'(want.key.w3), 64'(rsp_if.out_key_word3));
               check_field("out_kind_word0", want.kind.w0, rsp_if.out_kind_word0);
               check_field("out_kind_word1", want.kind.w1, rsp_if.out_kind_word1);
               check_field("out_kind_word2", 64'(want.kind.w2), 64'(rsp_if.out_kind_word2));
               check_field("out_amount", {32'h0, want.amount}, {32'h0, rsp_if.out_amount});
               check_field("last", 64'(want.last), 64'(rsp_if.last));
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // test tasks
   // --------------------------------------------------------------------------

   // every lookup on an empty table answers empty
   task automatic test_empty_table();
      send_request(FUNC_LIST, random_key(), random_kind(), $urandom);
      send_request(FUNC_SEARCH, random_key(), random_kind(), $urandom);
      send_request(FUNC_REMOVE, random_key(), random_kind(), $urandom);
      wait_for_drain();
   endtask

   // fill every slot with extreme fields and a duplicate name, overflow once, list all
   task automatic test_fill_to_capacity();
      key_type            k;
      kind_type           kd;
      logic signed [31:0] amt;
      for (int i = 0; i < CAPACITY; i++) begin
         k   = random_key();
         kd  = random_kind();
         amt = $urandom;
         case (i)
            0: begin
               k   = '0;
               kd  = '0;
               amt = 32'sh8000_0000;
            end
            1: begin
               k   = '1;
               kd  = '1;
               amt = 32'sh7fff_ffff;
            end
            2: begin
               amt      = -32'sd1;
               dup_name = k;
            end
            3: begin
               amt = '0;
            end
            5: begin
               // same name as slot 2, different type and quantity
               k = dup_name;
            end
            default: begin
            end
         endcase
         if (i == CAPACITY - 1) begin
            tail_name = k;
         end
         send_request(FUNC_INSERT, k, kd, amt);
      end
      send_request(FUNC_INSERT, random_key(), random_kind(), $urandom);
      send_request(FUNC_LIST, random_key(), random_kind(), $urandom);
      wait_for_drain();
   endtask

   // first match on duplicates, shift after remove, last slot, absent name
   task automatic test_duplicate_names();
      send_request(FUNC_SEARCH, dup_name, random_kind(), $urandom);
      send_request(FUNC_REMOVE, dup_name, random_kind(), $urandom);
      // the second copy has shifted down and is now the first match
      send_request(FUNC_SEARCH, dup_name, random_kind(), $urandom);
      send_request(FUNC_REMOVE, tail_name, random_kind(), $urandom);
      send_request(FUNC_REMOVE, near_miss('1), random_kind(), $urandom);
      send_request(FUNC_SEARCH, '0, random_kind(), $urandom);
      wait_for_drain();
   endtask

   // receiver holds off while long listings queue up, so the input must stall
   task automatic test_output_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (i % 2 == 0) begin
            send_request(FUNC_LIST, random_key(), random_kind(), $urandom);
         end else begin
            send_request(FUNC_SEARCH, pick_lookup_key(), random_kind(), $urandom);
         end
      end
      wait_for_drain();
   endtask

   // bursts of mixed requests; the mix swings between filling and emptying the table
   task automatic test_random_traffic(int n_items);
      int       burst_left;
      bit       growing;
      int       pick;
      func_type f;
      key_type  k;
      burst_left = 0;
      growing    = 1'b1;
      for (int i = 0; i < NAME_POOL; i++) begin
         name_pool[i] = random_key();
      end
      for (int i = 0; i < n_items; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
               pause_sender($urandom_range(1, 15));
            end
         end
         burst_left--;
         if (fill_count >= CAPACITY) begin
            growing = 1'b0;
         end else if (fill_count == 0) begin
            growing = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            f = FUNC_LIST;
         end else if (pick < 35) begin
            f = FUNC_SEARCH;
         end else if (pick < (growing ? 85 : 50)) begin
            f = FUNC_INSERT;
         end else begin
            f = FUNC_REMOVE;
         end
         if (f == FUNC_INSERT) begin
            k = ($urandom_range(0, 9) < 7) ? name_pool[$urandom_range(0, NAME_POOL - 1)]
                                           : random_key();
         end else begin
            k = pick_lookup_key();
         end
         send_request(f, k, random_kind(), $urandom);
      end
      wait_for_drain();
   endtask

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.func        = FUNC_INSERT;
      req_if.key_word0   = '0;
      req_if.key_word1   = '0;
      req_if.key_word2   = '0;
      req_if.key_word3   = '0;
      req_if.kind_word0  = '0;
      req_if.kind_word1  = '0;
      req_if.kind_word2  = '0;
      req_if.amount      = '0;
      rsp_if.ready       = 1'b0;
      fill_count         = 0;
      longest_list       = 0;
      results_checked    = 0;
      input_stall_cycles = 0;
      error_count        = 0;
      hold_request       = 1'b0;
      hold_left          = 0;
      stall_mode         = RX_STEADY;
      mode_left          = 0;
      rx_phase           = 0;
      for (int i = 0; i < 4; i++) begin
         func_seen[i]   = 0;
         status_seen[i] = 0;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fill_to_capacity();
      test_duplicate_names();
      test_output_backpressure();
      test_random_traffic(RANDOM_ITEMS);

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests (insert %0d, remove %0d, search %0d, list %0d), %0d results",
               func_seen[0] + func_seen[1] + func_seen[2] + func_seen[3], func_seen[0],
               func_seen[1], func_seen[2], func_seen[3], results_checked);
      $display("answers ok %0d, full %0d, empty %0d, not found %0d; longest listing %0d; %0d %s",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], longest_list,
               input_stall_cycles, "cycles of input back-pressure");
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // any expectation still waiting at the end counts as a failure above
endmodule

/* sim.f */
+incdir+design
design/slkt_pkg.sv
design/slkt_req_if.sv
design/slkt_rsp_if.sv
design/slkt_ram.sv
design/slkt_cmp.sv
design/sequential_list_keyed_table.sv
tb/tb_sequential_list_keyed_table.sv
